// ----- design/kpsd_pkg.sv -----
// Package for the keypad scan, debounce and control block.
// Holds the item and result types, key codes and control byte constants.
// No dependencies.
`default_nettype none

package kpsd_pkg;

    // Register indexes of the configuration port
    localparam logic [1:0] CFG_DEBOUNCE  = 2'd0;
    localparam logic [1:0] CFG_TMR_STEP  = 2'd1;
    localparam logic [1:0] CFG_TMR_MIN   = 2'd2;
    localparam logic [1:0] CFG_TMR_MAX   = 2'd3;

    // Key codes
    localparam logic [3:0] KEY_NONE  = 4'd0;
    localparam logic [3:0] KEY_POWER = 4'd1;
    localparam logic [3:0] KEY_TIMER = 4'd2;
    localparam logic [3:0] KEY_VOICE = 4'd3;
    localparam logic [3:0] KEY_AMP_UP = 4'd4;
    localparam logic [3:0] KEY_AMP_DN = 4'd5;
    localparam logic [3:0] KEY_HEAT  = 4'd6;
    localparam logic [3:0] KEY_AUTO  = 4'd7;
    localparam logic [3:0] KEY_MODE  = 4'd8;
    localparam logic [3:0] KEY_IDLE  = 4'd9;

    // Row sample patterns
    localparam logic [2:0] ROWS_HIGH = 3'b111;
    localparam logic [2:0] ROW1_LOW  = 3'b110;
    localparam logic [2:0] ROW2_LOW  = 3'b101;
    localparam logic [2:0] ROW3_LOW  = 3'b011;

    // Control byte masks
    localparam logic [7:0] PWR_BIT   = 8'h80;
    localparam logic [7:0] VOICE_BIT = 8'h80;
    localparam logic [7:0] AUTO_BIT  = 8'h08;
    localparam logic [7:0] AMP_MASK  = 8'h0f;
    localparam logic [7:0] HEAT_MASK = 8'h30;
    localparam logic [7:0] HEAT_CLR  = 8'hcf;
    localparam logic [7:0] HEAT_ONE  = 8'h10;
    localparam logic [7:0] MODE_CLR  = 8'hf8;
    localparam logic [2:0] MODE_LAST = 3'd6;
    localparam logic [2:0] MODE_FIRST = 3'd1;

    // Reset values of the configuration registers
    localparam logic [7:0] RST_DEBOUNCE = 8'd5;
    localparam logic [7:0] RST_TMR_STEP = 8'd5;
    localparam logic [7:0] RST_TMR_MIN  = 8'd15;
    localparam logic [7:0] RST_TMR_MAX  = 8'd30;

    typedef struct packed {
        logic       tick;
        logic [2:0] sense_idle;
        logic [2:0] sense_col0;
        logic [2:0] sense_col1;
        logic [2:0] sense_col2;
        logic       sys_on;
        logic       auto_on;
        logic       display_on;
    } t_item;

    typedef struct packed {
        logic [7:0] debounce_ticks;
        logic [7:0] timer_step;
        logic [7:0] timer_min;
        logic [7:0] timer_max;
    } t_cfg;

    typedef struct packed {
        logic [7:0] control_byte0;
        logic [7:0] control_byte1;
        logic [7:0] control_byte2;
        logic       key_accepted;
        logic [3:0] accepted_code;
    } t_result;

endpackage

`default_nettype wire

// ----- design/kpsd_decode.sv -----
// Key code decode from the four row samples of one scan.
// Depends on kpsd_pkg.
`default_nettype none

module kpsd_decode (
    input  wire logic [2:0] i_sense_idle,
    input  wire logic [2:0] i_sense_col0,
    input  wire logic [2:0] i_sense_col1,
    input  wire logic [2:0] i_sense_col2,
    output logic      [3:0] o_code
);

    logic [3:0] row;

    // Find the row from the all-columns sample
    always_comb begin
        case (i_sense_idle)
            kpsd_pkg::ROW1_LOW: row = 4'd1;
            kpsd_pkg::ROW2_LOW: row = 4'd2;
            kpsd_pkg::ROW3_LOW: row = 4'd3;
            default:            row = 4'd0;
        endcase
    end

    // Take the last active column; idle, no column or several rows give idle
    always_comb begin
        if (i_sense_idle == kpsd_pkg::ROWS_HIGH || row == 4'd0) begin
            o_code = kpsd_pkg::KEY_IDLE;
        end else if (i_sense_col2 != kpsd_pkg::ROWS_HIGH) begin
            o_code = row + 4'd6;
        end else if (i_sense_col1 != kpsd_pkg::ROWS_HIGH) begin
            o_code = row + 4'd3;
        end else if (i_sense_col0 != kpsd_pkg::ROWS_HIGH) begin
            o_code = row;
        end else begin
            o_code = kpsd_pkg::KEY_IDLE;
        end
    end

endmodule

`default_nettype wire

// ----- design/kpsd_core.sv -----
// Debounce and control byte state, updated once per advanced request.
// Depends on kpsd_pkg and kpsd_decode.
`default_nettype none

module kpsd_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire kpsd_pkg::t_item   i_item,
    input  wire kpsd_pkg::t_cfg    i_cfg,
    output kpsd_pkg::t_result      o_result
);

    logic [3:0] scan;
    logic [3:0] r_last, n_last;
    logic       r_pend, n_pend;
    logic [7:0] r_count, n_count;
    logic [3:0] r_acc, n_acc;
    logic [7:0] r_c0, n_c0;
    logic [7:0] r_c1, n_c1;
    logic [7:0] r_c2, n_c2;
    logic       accept;
    logic [7:0] tmr_sum;
    logic [2:0] mode;
    logic       on, disp;

    kpsd_decode u_decode (
        .i_sense_idle (i_item.sense_idle),
        .i_sense_col0 (i_item.sense_col0),
        .i_sense_col1 (i_item.sense_col1),
        .i_sense_col2 (i_item.sense_col2),
        .o_code       (scan)
    );

    assign tmr_sum = r_c2 + i_cfg.timer_step;
    assign mode    = r_c0[2:0];
    assign on      = i_item.sys_on;
    assign disp    = i_item.display_on;

    // Restart the countdown on a change, accept on zero, otherwise count down
    always_comb begin
        n_last  = r_last;
        n_pend  = r_pend;
        n_count = r_count;
        n_acc   = r_acc;
        accept  = 1'b0;
        if (i_item.tick) begin
            if (scan != r_last) begin
                n_last  = scan;
                n_pend  = 1'b1;
                n_count = i_cfg.debounce_ticks;
            end
            if (n_pend && n_count == 8'd0) begin
                n_pend = 1'b0;
                n_acc  = n_last;
                accept = 1'b1;
            end else if (n_pend) begin
                n_count = n_count - 8'd1;
            end
        end
    end

    // Apply the accepted key to the control bytes
    always_comb begin
        n_c0 = r_c0;
        n_c1 = r_c1;
        n_c2 = r_c2;
        if (accept) begin
            case (n_acc)
                kpsd_pkg::KEY_POWER: n_c0 = r_c0 ^ kpsd_pkg::PWR_BIT;
                kpsd_pkg::KEY_TIMER: begin
                    if (on) begin
                        if (tmr_sum > i_cfg.timer_max || tmr_sum < i_cfg.timer_min) begin
                            n_c2 = i_cfg.timer_min;
                        end else begin
                            n_c2 = tmr_sum;
                        end
                    end
                end
                kpsd_pkg::KEY_VOICE: begin
                    if (on) n_c1 = r_c1 ^ kpsd_pkg::VOICE_BIT;
                end
                kpsd_pkg::KEY_AMP_UP: begin
                    if (on && disp && (r_c1 & kpsd_pkg::AMP_MASK) != kpsd_pkg::AMP_MASK)
                        n_c1 = r_c1 + 8'd1;
                end
                kpsd_pkg::KEY_AMP_DN: begin
                    if (on && disp && (r_c1 & kpsd_pkg::AMP_MASK) != 8'd0)
                        n_c1 = r_c1 - 8'd1;
                end
                kpsd_pkg::KEY_HEAT: begin
                    if (on && disp) begin
                        if ((r_c1 & kpsd_pkg::HEAT_MASK) == kpsd_pkg::HEAT_MASK) begin
                            n_c1 = r_c1 & kpsd_pkg::HEAT_CLR;
                        end else begin
                            n_c1 = r_c1 + kpsd_pkg::HEAT_ONE;
                        end
                    end
                end
                kpsd_pkg::KEY_AUTO: begin
                    if (on && disp) n_c0 = r_c0 ^ kpsd_pkg::AUTO_BIT;
                end
                kpsd_pkg::KEY_MODE: begin
                    if (on && disp && !i_item.auto_on) begin
                        if (mode == kpsd_pkg::MODE_LAST) begin
                            n_c0 = (r_c0 & kpsd_pkg::MODE_CLR) | {5'd0, kpsd_pkg::MODE_FIRST};
                        end else begin
                            n_c0 = (r_c0 & kpsd_pkg::MODE_CLR) | {5'd0, mode + 3'd1};
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Hold state unless a request advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= kpsd_pkg::KEY_NONE;
            r_pend  <= 1'b0;
            r_count <= 8'd0;
            r_acc   <= kpsd_pkg::KEY_NONE;
            r_c0    <= 8'd0;
            r_c1    <= 8'd0;
            r_c2    <= 8'd0;
        end else if (i_advance) begin
            r_last  <= n_last;
            r_pend  <= n_pend;
            r_count <= n_count;
            r_acc   <= n_acc;
            r_c0    <= n_c0;
            r_c1    <= n_c1;
            r_c2    <= n_c2;
        end
    end

    assign o_result.control_byte0 = n_c0;
    assign o_result.control_byte1 = n_c1;
    assign o_result.control_byte2 = n_c2;
    assign o_result.key_accepted  = accept;
    assign o_result.accepted_code = n_acc;

endmodule

`default_nettype wire

// ----- design/keypad_scan_debounce_control.sv -----
// Top level of the keypad scan, debounce and control block.
// Depends on kpsd_pkg and kpsd_core.
`default_nettype none

// One scan request in gives one result out. Requests are taken into an input
// register and pass through the decode, debounce and control update logic into
// an output register, one request per cycle while the output is not stalled; the
// input side keeps accepting while a result waits, as long as the result
// register can move on in the same cycle. A request with tick low changes no
// state and returns the current control bytes. Configuration writes go
// straight to the four registers and take effect on the next request.
module keypad_scan_debounce_control (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tick[0], sense_idle[3:1], sense_col0[6:4], sense_col1[9:7],
    // sense_col2[12:10], sys_on[13], auto_on[14], display_on[15]
    input  wire logic [15:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // control_byte0[7:0], control_byte1[15:8], control_byte2[23:16],
    // key_accepted[24], accepted_code[28:25], zero[31:29]
    output logic      [31:0] m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    logic              r_in_valid;
    kpsd_pkg::t_item   r_item;
    logic              r_out_valid;
    kpsd_pkg::t_result r_result;
    kpsd_pkg::t_result result;
    kpsd_pkg::t_cfg    r_cfg;
    logic              advance;
    kpsd_pkg::t_item   in_item;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Unpack the request fields
    always_comb begin
        in_item.tick       = s_axis_tdata[0];
        in_item.sense_idle = s_axis_tdata[3:1];
        in_item.sense_col0 = s_axis_tdata[6:4];
        in_item.sense_col1 = s_axis_tdata[9:7];
        in_item.sense_col2 = s_axis_tdata[12:10];
        in_item.sys_on     = s_axis_tdata[13];
        in_item.auto_on    = s_axis_tdata[14];
        in_item.display_on = s_axis_tdata[15];
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= kpsd_pkg::RST_DEBOUNCE;
            r_cfg.timer_step     <= kpsd_pkg::RST_TMR_STEP;
            r_cfg.timer_min      <= kpsd_pkg::RST_TMR_MIN;
            r_cfg.timer_max      <= kpsd_pkg::RST_TMR_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                kpsd_pkg::CFG_DEBOUNCE: r_cfg.debounce_ticks <= i_cfg_data;
                kpsd_pkg::CFG_TMR_STEP: r_cfg.timer_step     <= i_cfg_data;
                kpsd_pkg::CFG_TMR_MIN:  r_cfg.timer_min      <= i_cfg_data;
                kpsd_pkg::CFG_TMR_MAX:  r_cfg.timer_max      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // Capture the request payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item <= in_item;
        end
    end

    kpsd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_item),
        .i_cfg     (r_cfg),
        .o_result  (result)
    );

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_result.accepted_code, r_result.key_accepted,
                            r_result.control_byte2, r_result.control_byte1,
                            r_result.control_byte0};

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for keypad_scan_debounce_control.
// Drives scan requests and configuration writes, predicts every control result
// and checks it; depends on kpsd_pkg and the design files.
`default_nettype none

module tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tick[0], sense_idle[3:1], sense_col0[6:4], sense_col1[9:7],
    // sense_col2[12:10], sys_on[13], auto_on[14], display_on[15]
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // control_byte0[7:0], control_byte1[15:8], control_byte2[23:16],
    // key_accepted[24], accepted_code[28:25], zero[31:29]
    logic [31:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;

    keypad_scan_debounce_control DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock: period 10
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Scan requests waiting to be sent and control results still owed
    kpsd_pkg::t_item   scan_queue[$];
    kpsd_pkg::t_result expected_panel[$];
    kpsd_pkg::t_item   drv_req;
    kpsd_pkg::t_item   next_req;
    int      queued_count = 0;
    int      taken_count = 0;
    int      mismatches = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    // Predictor copy of the configuration and the panel state
    logic [7:0] cfg_debounce = kpsd_pkg::RST_DEBOUNCE;
    logic [7:0] cfg_step     = kpsd_pkg::RST_TMR_STEP;
    logic [7:0] cfg_tmin     = kpsd_pkg::RST_TMR_MIN;
    logic [7:0] cfg_tmax     = kpsd_pkg::RST_TMR_MAX;
    logic [3:0] scan_last    = kpsd_pkg::KEY_NONE;
    logic       scan_pending = 1'b0;
    logic [7:0] settle_count = '0;
    logic [3:0] held_key     = kpsd_pkg::KEY_NONE;
    logic [7:0] panel0 = '0;
    logic [7:0] panel1 = '0;
    logic [7:0] panel2 = '0;

    function automatic logic [15:0] pack_scan(kpsd_pkg::t_item r);
        return {r.display_on, r.auto_on, r.sys_on, r.sense_col2, r.sense_col1,
                r.sense_col0, r.sense_idle, r.tick};
    endfunction

    // Decode the four row samples into a key code
    function automatic logic [3:0] decode_key(kpsd_pkg::t_item r);
        int         row;
        int         col;
        if (r.sense_idle == kpsd_pkg::ROWS_HIGH) return kpsd_pkg::KEY_IDLE;
        case (r.sense_idle)
            kpsd_pkg::ROW1_LOW: row = 1;
            kpsd_pkg::ROW2_LOW: row = 2;
            kpsd_pkg::ROW3_LOW: row = 3;
            default:            row = 0;
        endcase
        col = -1;
        if (r.sense_col0 != kpsd_pkg::ROWS_HIGH) col = 0;
        if (r.sense_col1 != kpsd_pkg::ROWS_HIGH) col = 1;
        if (r.sense_col2 != kpsd_pkg::ROWS_HIGH) col = 2;
        if (col < 0 || row == 0) return kpsd_pkg::KEY_IDLE;
        return 4'(col * 3 + row);
    endfunction

    // Advance the debounce and panel state by one request, queue the result
    task automatic predict_panel(kpsd_pkg::t_item r);
        kpsd_pkg::t_result res;
        logic [3:0] code;
        logic [2:0] mode;
        logic       hit;
        hit = 1'b0;
        if (r.tick) begin
            code = decode_key(r);
            if (code != scan_last) begin
                scan_pending = 1'b1;
                scan_last    = code;
                settle_count = cfg_debounce;
            end
            if (scan_pending && settle_count == 0) begin
                scan_pending = 1'b0;
                held_key     = scan_last;
                hit          = 1'b1;
            end
            if (scan_pending && settle_count > 0) settle_count = settle_count - 1'b1;
            if (hit) begin
                case (held_key)
                    kpsd_pkg::KEY_POWER: panel0 = panel0 ^ kpsd_pkg::PWR_BIT;
                    kpsd_pkg::KEY_TIMER: if (r.sys_on) begin
                        panel2 = panel2 + cfg_step;
                        if (panel2 > cfg_tmax || panel2 < cfg_tmin) panel2 = cfg_tmin;
                    end
                    kpsd_pkg::KEY_VOICE: if (r.sys_on) panel1 = panel1 ^ kpsd_pkg::VOICE_BIT;
                    kpsd_pkg::KEY_AMP_UP: if (r.sys_on && r.display_on
                        && (panel1 & kpsd_pkg::AMP_MASK) != kpsd_pkg::AMP_MASK) begin
                        panel1 = panel1 + 8'd1;
                    end
                    kpsd_pkg::KEY_AMP_DN: if (r.sys_on && r.display_on
                        && (panel1 & kpsd_pkg::AMP_MASK) != 8'd0) begin
                        panel1 = panel1 - 8'd1;
                    end
                    kpsd_pkg::KEY_HEAT: if (r.sys_on && r.display_on) begin
                        if ((panel1 & kpsd_pkg::HEAT_MASK) == kpsd_pkg::HEAT_MASK)
                            panel1 = panel1 & kpsd_pkg::HEAT_CLR;
                        else
                            panel1 = panel1 + kpsd_pkg::HEAT_ONE;
                    end
                    kpsd_pkg::KEY_AUTO: if (r.sys_on && r.display_on) begin
                        panel0 = panel0 ^ kpsd_pkg::AUTO_BIT;
                    end
                    kpsd_pkg::KEY_MODE: if (r.sys_on && r.display_on && !r.auto_on) begin
                        mode = panel0[2:0];
                        mode = (mode == kpsd_pkg::MODE_LAST) ? kpsd_pkg::MODE_FIRST
                                                             : mode + 3'd1;
                        panel0 = (panel0 & kpsd_pkg::MODE_CLR) | {5'd0, mode};
                    end
                    default: ;
                endcase
            end
        end
        res.control_byte0 = panel0;
        res.control_byte1 = panel1;
        res.control_byte2 = panel2;
        res.key_accepted  = hit;
        res.accepted_code = held_key;
        expected_panel.push_back(res);
    endtask

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %0h, expected %0h", field, got, want);
        mismatches++;
    endtask

    // Compare one result with the oldest expectation
    task automatic check_panel(logic [31:0] data);
        kpsd_pkg::t_result want;
        if (expected_panel.size() == 0) begin
            report_mismatch("unexpected result", data, 32'd0);
        end else begin
            want = expected_panel.pop_front();
            if (data[7:0] != want.control_byte0)
                report_mismatch("control_byte0", 32'(data[7:0]), 32'(want.control_byte0));
            if (data[15:8] != want.control_byte1)
                report_mismatch("control_byte1", 32'(data[15:8]), 32'(want.control_byte1));
            if (data[23:16] != want.control_byte2)
                report_mismatch("control_byte2", 32'(data[23:16]), 32'(want.control_byte2));
            if (data[24] != want.key_accepted)
                report_mismatch("key_accepted", 32'(data[24]), 32'(want.key_accepted));
            if (data[28:25] != want.accepted_code)
                report_mismatch("accepted_code", 32'(data[28:25]), 32'(want.accepted_code));
            if (data[31:29] != 3'd0)
                report_mismatch("padding", 32'(data[31:29]), 32'd0);
        end
    endtask

    // Driver: predict on acceptance, then offer the next request or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_panel(drv_req);
                taken_count++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (scan_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = scan_queue.pop_front();
                    drv_req       <= next_req;
                    s_axis_tdata  <= pack_scan(next_req);
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check accepted results, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_panel(m_axis_tdata);
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Build one scan with a key held (1..8) or released (idle code)
    function automatic kpsd_pkg::t_item make_scan(int key);
        kpsd_pkg::t_item r;
        logic [2:0] pat;
        int         col;
        r = kpsd_pkg::t_item'(16'($urandom));
        r.tick       = 1'b1;
        r.sys_on     = ($urandom_range(9) != 0);
        r.display_on = ($urandom_range(19) >= 3);
        r.auto_on    = ($urandom_range(9) < 3);
        if (key == int'(kpsd_pkg::KEY_IDLE)) begin
            r.sense_idle = kpsd_pkg::ROWS_HIGH;
        end else begin
            col = (key - 1) / 3;
            case ((key - 1) % 3)
                0:       pat = kpsd_pkg::ROW1_LOW;
                1:       pat = kpsd_pkg::ROW2_LOW;
                default: pat = kpsd_pkg::ROW3_LOW;
            endcase
            r.sense_idle = pat;
            if (col == 0) begin
                r.sense_col0 = pat;
                r.sense_col1 = kpsd_pkg::ROWS_HIGH;
                r.sense_col2 = kpsd_pkg::ROWS_HIGH;
            end else if (col == 1) begin
                r.sense_col1 = pat;
                r.sense_col2 = kpsd_pkg::ROWS_HIGH;
            end else begin
                r.sense_col2 = pat;
            end
        end
        return r;
    endfunction

    task automatic push_scan(kpsd_pkg::t_item r);
        scan_queue.push_back(r);
        queued_count++;
    endtask

    // Hold a key for n ticks, with the odd tick-low request mixed in
    task automatic queue_hold(int key, int n);
        kpsd_pkg::t_item r;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) begin
                r = kpsd_pkg::t_item'(16'($urandom));
                r.tick = 1'b0;
                push_scan(r);
            end
            push_scan(make_scan(key));
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            kpsd_pkg::CFG_DEBOUNCE: cfg_debounce = val;
            kpsd_pkg::CFG_TMR_STEP: cfg_step = val;
            kpsd_pkg::CFG_TMR_MIN:  cfg_tmin = val;
            kpsd_pkg::CFG_TMR_MAX:  cfg_tmax = val;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [7:0] d, logic [7:0] st, logic [7:0] mn, logic [7:0] mx);
        write_reg(kpsd_pkg::CFG_DEBOUNCE, d);
        write_reg(kpsd_pkg::CFG_TMR_STEP, st);
        write_reg(kpsd_pkg::CFG_TMR_MIN, mn);
        write_reg(kpsd_pkg::CFG_TMR_MAX, mx);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every request is taken and every result has arrived
    task automatic wait_drained();
        while (taken_count != queued_count || expected_panel.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly clean press/release pairs, some bounces and raw noise
    task automatic run_random(int n_items, int favored);
        int target;
        int key;
        int pick;
        target = queued_count + n_items;
        while (queued_count < target) begin
            pick = $urandom_range(99);
            key  = ($urandom_range(9) < 4) ? favored : $urandom_range(1, 8);
            if (pick < 80) begin
                queue_hold(key, int'(cfg_debounce) + 1 + $urandom_range(3));
                queue_hold(int'(kpsd_pkg::KEY_IDLE), int'(cfg_debounce) + 1 + $urandom_range(3));
            end else if (pick < 90) begin
                queue_hold(key, $urandom_range(1, int'(cfg_debounce) + 1));
            end else begin
                push_scan(kpsd_pkg::t_item'(16'($urandom)));
            end
        end
    endtask

    // Directed sequence: every key, gating cases and the idle-code cases
    task automatic run_directed();
        kpsd_pkg::t_item r;
        r = kpsd_pkg::t_item'(16'($urandom));
        r.tick = 1'b0;
        push_scan(r);
        r = make_scan(kpsd_pkg::KEY_POWER);
        r.sys_on = 1'b0;
        push_scan(r);
        r = make_scan(kpsd_pkg::KEY_TIMER);
        r.sys_on = 1'b1;
        push_scan(r);
        r = make_scan(kpsd_pkg::KEY_IDLE);
        push_scan(r);
        r = make_scan(kpsd_pkg::KEY_TIMER);
        r.sys_on = 1'b1;
        push_scan(r);
        r = make_scan(kpsd_pkg::KEY_VOICE);
        r.sys_on = 1'b1;
        push_scan(r);
        r = make_scan(kpsd_pkg::KEY_AMP_DN);
        r.sys_on = 1'b1; r.display_on = 1'b1;
        push_scan(r);
        r = make_scan(kpsd_pkg::KEY_AMP_UP);
        r.sys_on = 1'b1; r.display_on = 1'b1;
        push_scan(r);
        r = make_scan(kpsd_pkg::KEY_HEAT);
        r.sys_on = 1'b1; r.display_on = 1'b1;
        push_scan(r);
        r = make_scan(kpsd_pkg::KEY_MODE);
        r.sys_on = 1'b1; r.display_on = 1'b1; r.auto_on = 1'b0;
        push_scan(r);
        r = make_scan(kpsd_pkg::KEY_AUTO);
        r.sys_on = 1'b1; r.display_on = 1'b1;
        push_scan(r);
        r = make_scan(kpsd_pkg::KEY_MODE);
        r.sys_on = 1'b1; r.display_on = 1'b1; r.auto_on = 1'b1;
        push_scan(r);
        r = make_scan(kpsd_pkg::KEY_HEAT);
        r.sys_on = 1'b1; r.display_on = 1'b0;
        push_scan(r);
        r = make_scan(kpsd_pkg::KEY_VOICE);
        r.sys_on = 1'b0;
        push_scan(r);
        // several rows low at once
        r = make_scan(kpsd_pkg::KEY_HEAT);
        r.sense_idle = 3'b000;
        push_scan(r);
        r = make_scan(kpsd_pkg::KEY_POWER);
        push_scan(r);
        // row seen but every column sample high
        r = make_scan(kpsd_pkg::KEY_AMP_UP);
        r.sense_col0 = kpsd_pkg::ROWS_HIGH;
        r.sense_col1 = kpsd_pkg::ROWS_HIGH;
        r.sense_col2 = kpsd_pkg::ROWS_HIGH;
        push_scan(r);
        r = make_scan(kpsd_pkg::KEY_TIMER);
        r.sys_on = 1'b1;
        push_scan(r);
        // last key of the last column reads as the idle code
        r = make_scan(kpsd_pkg::KEY_AUTO);
        r.sense_idle = kpsd_pkg::ROW3_LOW;
        r.sense_col2 = kpsd_pkg::ROW3_LOW;
        push_scan(r);
        r = make_scan(kpsd_pkg::KEY_IDLE);
        push_scan(r);
    endtask

    // Run phases: reset config, extremes, random with varied pacing, then the longest countdown
    initial begin
        kpsd_pkg::t_item r;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset-valued registers: two timer presses, the first from below the minimum
        for (int k = 0; k < 2; k++) begin
            for (int i = 0; i < 7; i++) begin
                r = make_scan(kpsd_pkg::KEY_TIMER);
                r.sys_on = 1'b1;
                push_scan(r);
            end
            for (int i = 0; i < 6; i++) push_scan(make_scan(kpsd_pkg::KEY_IDLE));
        end
        wait_drained();

        set_config(8'd0, 8'd255, 8'd0, 8'd255);
        run_directed();
        wait_drained();

        set_config(8'd2, 8'd7, 8'd10, 8'd40);
        run_random(170, kpsd_pkg::KEY_AMP_UP);
        wait_drained();

        send_idle_pct = 72;
        set_config(8'd1, 8'd200, 8'd100, 8'd255);
        run_random(170, kpsd_pkg::KEY_MODE);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 72;
        set_config(8'd3, 8'd13, 8'd0, 8'd60);
        run_random(170, kpsd_pkg::KEY_AMP_DN);
        wait_drained();

        send_idle_pct  = 35;
        recv_stall_pct = 35;
        set_config(8'd0, 8'd255, 8'd0, 8'd255);
        run_random(170, kpsd_pkg::KEY_HEAT);
        wait_drained();

        // longest countdown, timer range empty so every press lands on the minimum
        set_config(8'd255, 8'd0, 8'd255, 8'd0);
        for (int i = 0; i < 257; i++) begin
            r = make_scan(kpsd_pkg::KEY_TIMER);
            r.sys_on = 1'b1;
            push_scan(r);
        end
        queue_hold(int'(kpsd_pkg::KEY_IDLE), 257);
        wait_drained();

        repeat (6) @(posedge i_clk);
        if (expected_panel.size() != 0)
            report_mismatch("results left over", 32'(expected_panel.size()), 32'd0);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
